FILE: hw/rtl/hfts_pkg.sv
// ----------------------------------------------------------------------------
// hfts_pkg
// Shared types and constants of the HDLC transmit framer.
// ----------------------------------------------------------------------------
`default_nettype none

package hfts_pkg;

  localparam int STUFF_RUN   = 5;
  localparam int MAX_RESULTS = 45;
  localparam int RES_CNT_W   = $clog2(MAX_RESULTS + 1);

  localparam int QUEUE_DEPTH = 2;
  localparam int Q_PTR_W     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int Q_CNT_W     = $clog2(QUEUE_DEPTH + 1);

  localparam logic [15:0] CRC_POLY   = 16'h8408;
  localparam logic [15:0] CRC_PRESET = 16'hFFFF;
  localparam logic [7:0]  FLAG_RESET = 8'h7E;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_MSB_FIRST    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_FLAG_PATTERN = 1'b1;

  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_STUFF = 2'd1,
    KIND_FCS   = 2'd2,
    KIND_FLAG  = 2'd3
  } kind_t;

  typedef enum logic [5:0] {
    PH_IDLE       = 6'b000001,
    PH_FLAG_OPEN  = 6'b000010,
    PH_DATA       = 6'b000100,
    PH_FCS_LO     = 6'b001000,
    PH_FCS_HI     = 6'b010000,
    PH_FLAG_CLOSE = 6'b100000
  } phase_t;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        frame_start;
    logic        frame_end;
    logic [15:0] fcs;
  } job_t;

endpackage

`default_nettype wire

FILE: hw/rtl/hfts_in_if.sv
// ----------------------------------------------------------------------------
// hfts_in_if
// Input channel: one raw frame byte per item with its frame markers.
// ----------------------------------------------------------------------------
`default_nettype none

interface hfts_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       frame_start;
  logic       frame_end;

  modport source (output valid, data_byte, frame_start, frame_end, input ready);
  modport sink   (input valid, data_byte, frame_start, frame_end, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/hfts_out_if.sv
// ----------------------------------------------------------------------------
// hfts_out_if
// Result channel: one line bit per item with its kind and last marker.
// ----------------------------------------------------------------------------
`default_nettype none

interface hfts_out_if;
  logic       valid;
  logic       ready;
  logic       line_bit;
  logic [1:0] bit_kind;
  logic       run_last;

  modport source (output valid, line_bit, bit_kind, run_last, input ready);
  modport sink   (input valid, line_bit, bit_kind, run_last, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/hfts_front.sv
// ----------------------------------------------------------------------------
// hfts_front
// Accepts frame bytes, drops bytes outside a frame, runs the FCS-16 and
// builds one job per byte for the serializer.
// ----------------------------------------------------------------------------
`default_nettype none

module hfts_front (
  input  wire logic          clk,
  input  wire logic          rst_n,
  hfts_in_if.sink            in_ch,
  input  wire logic          queue_full,
  output logic               push,
  output hfts_pkg::job_t     push_job
);
  import hfts_pkg::*;

  function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] r;
    r = c ^ {8'h00, b};
    for (int j = 0; j < 8; j++) begin
      r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
    end
    return r;
  endfunction

  logic [15:0] crc_r, crc_nxt, crc_new;
  logic        in_frame_r, in_frame_nxt;
  logic        accept, drop;

  assign in_ch.ready = !queue_full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign drop        = !in_ch.frame_start && !in_frame_r;
  assign crc_new     = crc_byte(in_ch.frame_start ? CRC_PRESET : crc_r, in_ch.data_byte);
  assign push        = accept && !drop;

  always_comb begin
    push_job.data_byte   = in_ch.data_byte;
    push_job.frame_start = in_ch.frame_start;
    push_job.frame_end   = in_ch.frame_end;
    push_job.fcs         = ~crc_new;
  end

  always_comb begin
    crc_nxt      = crc_r;
    in_frame_nxt = in_frame_r;
    if (push) begin
      if (in_ch.frame_end) begin
        crc_nxt      = CRC_PRESET;
        in_frame_nxt = 1'b0;
      end else begin
        crc_nxt      = crc_new;
        in_frame_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r      <= CRC_PRESET;
      in_frame_r <= 1'b0;
    end else begin
      crc_r      <= crc_nxt;
      in_frame_r <= in_frame_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/hfts_queue.sv
// ----------------------------------------------------------------------------
// hfts_queue
// Short job queue between front and serializer.
// ----------------------------------------------------------------------------
`default_nettype none

module hfts_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  hfts_pkg::job_t     push_job,
  output logic               full,
  input  wire logic          pop,
  output logic               head_valid,
  output hfts_pkg::job_t     head_job
);
  import hfts_pkg::*;

  job_t               mem_r [QUEUE_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_W-1:0] cnt_r, cnt_nxt;

  assign full       = (cnt_r == Q_CNT_W'(QUEUE_DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_job   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == Q_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == Q_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/hfts_back.sv
// ----------------------------------------------------------------------------
// hfts_back
// Serializer: sends flags, data and FCS one line bit per cycle, while a job is queued
// and the output is not stalled, with zero stuffing, into a registered result stage.
// ----------------------------------------------------------------------------
`default_nettype none

module hfts_back (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          head_valid,
  input  hfts_pkg::job_t     head_job,
  output logic               pop,
  input  wire logic          msb_first,
  input  wire logic [7:0]    flag_pattern,
  hfts_out_if.source         out_ch
);
  import hfts_pkg::*;

  phase_t               phase_r, phase_nxt, eff_phase, next_phase;
  logic [2:0]           idx_r, idx_nxt;
  logic                 stuff_pend_r, stuff_pend_nxt;
  logic [2:0]           ones_r, ones_nxt, ones_inc;
  logic [RES_CNT_W-1:0] res_cnt_r, res_cnt_nxt;

  logic                 out_valid_r, out_valid_nxt;
  logic                 line_bit_r, line_bit_nxt;
  kind_t                bit_kind_r, bit_kind_nxt;
  logic                 run_last_r, run_last_nxt;

  logic       emit, cur_bit, is_flag, need_stuff, byte_done, natural_done, cap_hit, item_done;
  logic [7:0] cur_byte;
  kind_t      cur_kind;

  assign out_ch.valid    = out_valid_r;
  assign out_ch.line_bit = line_bit_r;
  assign out_ch.bit_kind = bit_kind_r;
  assign out_ch.run_last = run_last_r;

  assign emit = head_valid && (!out_valid_r || out_ch.ready);

  always_comb begin
    if (phase_r == PH_IDLE) begin
      eff_phase = head_job.frame_start ? PH_FLAG_OPEN : PH_DATA;
    end else begin
      eff_phase = phase_r;
    end
  end

  always_comb begin
    cur_byte   = head_job.data_byte;
    cur_kind   = KIND_DATA;
    is_flag    = 1'b0;
    next_phase = PH_IDLE;
    unique case (eff_phase)
      PH_FLAG_OPEN: begin
        cur_byte   = flag_pattern;
        cur_kind   = KIND_FLAG;
        is_flag    = 1'b1;
        next_phase = PH_DATA;
      end
      PH_DATA: begin
        next_phase = head_job.frame_end ? PH_FCS_LO : PH_IDLE;
      end
      PH_FCS_LO: begin
        cur_byte   = head_job.fcs[7:0];
        cur_kind   = KIND_FCS;
        next_phase = PH_FCS_HI;
      end
      PH_FCS_HI: begin
        cur_byte   = head_job.fcs[15:8];
        cur_kind   = KIND_FCS;
        next_phase = PH_FLAG_CLOSE;
      end
      PH_FLAG_CLOSE: begin
        cur_byte   = flag_pattern;
        cur_kind   = KIND_FLAG;
        is_flag    = 1'b1;
        next_phase = PH_IDLE;
      end
      default: begin
        next_phase = PH_IDLE;
      end
    endcase
  end

  assign cur_bit    = msb_first ? cur_byte[3'd7 - idx_r] : cur_byte[idx_r];
  assign ones_inc   = ones_r + 3'd1;
  assign need_stuff = !stuff_pend_r && !is_flag && cur_bit && (ones_inc >= 3'(STUFF_RUN));

  always_comb begin
    if (stuff_pend_r) begin
      byte_done = (idx_r == 3'd0);
    end else begin
      byte_done = (idx_r == 3'd7) && !need_stuff;
    end
  end

  assign natural_done = byte_done && (next_phase == PH_IDLE);
  assign cap_hit      = (res_cnt_r == RES_CNT_W'(MAX_RESULTS - 1));
  assign item_done    = natural_done || cap_hit;
  assign pop          = emit && item_done;

  always_comb begin
    phase_nxt      = phase_r;
    idx_nxt        = idx_r;
    stuff_pend_nxt = stuff_pend_r;
    ones_nxt       = ones_r;
    res_cnt_nxt    = res_cnt_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    line_bit_nxt   = line_bit_r;
    bit_kind_nxt   = bit_kind_r;
    run_last_nxt   = run_last_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
      run_last_nxt  = item_done;
      if (stuff_pend_r) begin
        line_bit_nxt   = 1'b0;
        bit_kind_nxt   = KIND_STUFF;
        stuff_pend_nxt = 1'b0;
        ones_nxt       = '0;
      end else begin
        line_bit_nxt   = cur_bit;
        bit_kind_nxt   = cur_kind;
        idx_nxt        = idx_r + 3'd1;
        stuff_pend_nxt = need_stuff;
        if (is_flag || !cur_bit || need_stuff) begin
          ones_nxt = '0;
        end else begin
          ones_nxt = ones_inc;
        end
      end
      if (item_done) begin
        phase_nxt      = PH_IDLE;
        idx_nxt        = '0;
        stuff_pend_nxt = 1'b0;
        res_cnt_nxt    = '0;
        if (!natural_done) begin
          ones_nxt = '0;
        end
      end else begin
        phase_nxt   = byte_done ? next_phase : eff_phase;
        res_cnt_nxt = res_cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      idx_r        <= '0;
      stuff_pend_r <= 1'b0;
      ones_r       <= '0;
      res_cnt_r    <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      phase_r      <= phase_nxt;
      idx_r        <= idx_nxt;
      stuff_pend_r <= stuff_pend_nxt;
      ones_r       <= ones_nxt;
      res_cnt_r    <= res_cnt_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    line_bit_r <= line_bit_nxt;
    bit_kind_r <= bit_kind_nxt;
    run_last_r <= run_last_nxt;
  end

endmodule

`default_nettype wire

FILE: hw/rtl/hdlc_frame_tx_fcs_bitstuff.sv
// The first line bit of an item becomes valid after the job queue and the registered
// result stage. The serializer sends one line bit per cycle unless the output stalls
// or the queue is empty; a start byte adds the opening flag, an end byte the FCS and flag.
// A two-entry job queue lets the input take new bytes while the serializer works.
// Reset (synchronous, active low): queue and output empty, CRC preset, no frame open,
// MSB first and flag pattern 0x7E.
// ----------------------------------------------------------------------------
// hdlc_frame_tx_fcs_bitstuff
// HDLC transmit framer: flags, FCS-16 and zero-bit stuffing onto a bit stream.
// ----------------------------------------------------------------------------
`default_nettype none

module hdlc_frame_tx_fcs_bitstuff (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  hfts_in_if.sink                              in_ch,
  hfts_out_if.source                           out_ch,
  input  wire logic                            cfg_we,
  input  wire logic [hfts_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [hfts_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import hfts_pkg::*;

  logic       msb_first_r, msb_first_nxt;
  logic [7:0] flag_pattern_r, flag_pattern_nxt;

  logic push, queue_full, pop, head_valid;
  job_t push_job, head_job;

  always_comb begin
    msb_first_nxt    = msb_first_r;
    flag_pattern_nxt = flag_pattern_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_MSB_FIRST:    msb_first_nxt    = cfg_wdata[0];
        CFG_FLAG_PATTERN: flag_pattern_nxt = cfg_wdata[7:0];
        default: begin
          msb_first_nxt = msb_first_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      msb_first_r    <= 1'b1;
      flag_pattern_r <= FLAG_RESET;
    end else begin
      msb_first_r    <= msb_first_nxt;
      flag_pattern_r <= flag_pattern_nxt;
    end
  end

  hfts_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .queue_full (queue_full),
    .push       (push),
    .push_job   (push_job)
  );

  hfts_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_job   (push_job),
    .full       (queue_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_job   (head_job)
  );

  hfts_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .head_valid   (head_valid),
    .head_job     (head_job),
    .pop          (pop),
    .msb_first    (msb_first_r),
    .flag_pattern (flag_pattern_r),
    .out_ch       (out_ch)
  );

endmodule

`default_nettype wire
